// ===== rtl/fbhp_pkg.sv =====
// Shared types, codes and tables for the bit file header parser.
// No dependencies; imported by every module of the block but fbhp_fifo.
package fbhp_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF   = 2;

  // Result status codes
  localparam logic [1:0] ST_PARSING  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_MAGIC_SIZE = 3'd1;
  localparam logic [2:0] ERR_MAGIC      = 3'd2;
  localparam logic [2:0] ERR_A_LEN      = 3'd3;
  localparam logic [2:0] ERR_A_CHAR     = 3'd4;
  localparam logic [2:0] ERR_NAME_TERM  = 3'd5;
  localparam logic [2:0] ERR_B_CHAR     = 3'd6;
  localparam logic [2:0] ERR_PART_TERM  = 3'd7;

  localparam logic [7:0]  CHAR_A        = 8'h61;
  localparam logic [7:0]  CHAR_B        = 8'h62;
  localparam logic [15:0] MAGIC_SIZE    = 16'd9;
  localparam logic [15:0] A_LEN         = 16'd1;
  localparam logic [15:0] MAGIC_LAST    = 16'd8;

  typedef enum logic [12:0] {
    PH_MLEN_HI = 13'h0001,
    PH_MLEN_LO = 13'h0002,
    PH_MAGIC   = 13'h0004,
    PH_ALEN_HI = 13'h0008,
    PH_ALEN_LO = 13'h0010,
    PH_ACHAR   = 13'h0020,
    PH_NLEN_HI = 13'h0040,
    PH_NLEN_LO = 13'h0080,
    PH_NAME    = 13'h0100,
    PH_BCHAR   = 13'h0200,
    PH_PLEN_HI = 13'h0400,
    PH_PLEN_LO = 13'h0800,
    PH_PART    = 13'h1000
  } phase_t;

  // Classified input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       is_zero;
    logic       is_a;
    logic       is_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] error_code;
    logic [7:0] part_byte;
    logic       part_valid;
    logic       part_last;
  } out_item_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6: v = 8'h0f;
      4'd1, 4'd3, 4'd5, 4'd7: v = 8'hf0;
      default:                v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/fbhp_fifo.sv =====
// Small synchronous FIFO used as the decoupling and result queues.
// No dependencies.
module fbhp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_rd) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_wr && !do_rd)      count_r <= CW'(count_r + 1'b1);
      else if (do_rd && !do_wr) count_r <= CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/fbhp_front.sv =====
// Front end: takes input transactions and classifies the byte.
// Depends on fbhp_pkg.
module fbhp_front (
  input  logic              push,
  input  logic [7:0]        in_data_byte,
  input  logic              in_restart,
  input  logic              q_full,
  output logic              q_wr,
  output fbhp_pkg::in_item_t q_item
);
  import fbhp_pkg::*;

  assign q_wr = push && !q_full;

  always_comb begin
    q_item.data_byte = in_data_byte;
    q_item.restart   = in_restart;
    q_item.is_zero   = (in_data_byte == 8'h00);
    q_item.is_a      = (in_data_byte == CHAR_A);
    q_item.is_b      = (in_data_byte == CHAR_B);
  end

endmodule

// ===== rtl/fbhp_back.sv =====
// Back end: header sequencer, one classified byte per cycle unless the result queue is full.
// Depends on fbhp_pkg.
module fbhp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fbhp_pkg::in_item_t  q_item,
  input  logic                q_empty,
  output logic                q_rd,
  input  logic                res_full,
  output logic                res_wr,
  output fbhp_pkg::out_item_t res_item
);
  import fbhp_pkg::*;

  phase_t      phase_r, phase_nxt, ph;
  logic [15:0] bc_r, bc_nxt, bc;
  logic [15:0] fl_r, fl_nxt, fl;
  logic        fin_r, fin_nxt, fin;
  logic        fire;
  logic [15:0] fl_lo;
  logic [16:0] bc_p1, bc_p2;
  logic        last_byte;
  logic [3:0]  midx;
  logic [7:0]  b;

  assign fire   = !q_empty && !res_full;
  assign q_rd   = fire;
  assign res_wr = fire;
  assign b      = q_item.data_byte;

  always_comb begin
    // restart clears state before the byte is parsed
    ph  = q_item.restart ? PH_MLEN_HI : phase_r;
    bc  = q_item.restart ? 16'd0 : bc_r;
    fl  = q_item.restart ? 16'd0 : fl_r;
    fin = q_item.restart ? 1'b0 : fin_r;

    fl_lo     = fl | {8'h00, b};
    bc_p1     = {1'b0, bc} + 17'd1;
    bc_p2     = {1'b0, bc} + 17'd2;
    last_byte = (bc_p1 >= {1'b0, fl});
    midx      = (bc < MAGIC_SIZE) ? bc[3:0] : MAGIC_LAST[3:0];

    phase_nxt = ph;
    bc_nxt    = bc;
    fl_nxt    = fl;
    fin_nxt   = fin;
    res_item  = '0;

    if (fin) begin
      res_item.status = ST_IGNORED;
    end else begin
      unique case (ph)
        PH_MLEN_HI: begin fl_nxt = {b, 8'h00}; phase_nxt = PH_MLEN_LO; end
        PH_ALEN_HI: begin fl_nxt = {b, 8'h00}; phase_nxt = PH_ALEN_LO; end
        PH_NLEN_HI: begin fl_nxt = {b, 8'h00}; phase_nxt = PH_NLEN_LO; end
        PH_PLEN_HI: begin fl_nxt = {b, 8'h00}; phase_nxt = PH_PLEN_LO; end
        PH_MLEN_LO: begin
          fl_nxt = fl_lo;
          if (fl_lo != MAGIC_SIZE) begin
            res_item.status     = ST_ERROR;
            res_item.error_code = ERR_MAGIC_SIZE;
          end else begin
            phase_nxt = PH_MAGIC;
            bc_nxt    = 16'd0;
          end
        end
        PH_MAGIC: begin
          if (b != magic_byte(midx)) begin
            res_item.status     = ST_ERROR;
            res_item.error_code = ERR_MAGIC;
          end else if (bc >= MAGIC_LAST) begin
            phase_nxt = PH_ALEN_HI;
          end else begin
            bc_nxt = bc_p1[15:0];
          end
        end
        PH_ALEN_LO: begin
          fl_nxt = fl_lo;
          if (fl_lo != A_LEN) begin
            res_item.status     = ST_ERROR;
            res_item.error_code = ERR_A_LEN;
          end else begin
            phase_nxt = PH_ACHAR;
          end
        end
        PH_ACHAR: begin
          if (!q_item.is_a) begin
            res_item.status     = ST_ERROR;
            res_item.error_code = ERR_A_CHAR;
          end else begin
            phase_nxt = PH_NLEN_HI;
          end
        end
        PH_NLEN_LO: begin
          fl_nxt = fl_lo;
          bc_nxt = 16'd0;
          if (fl_lo == 16'd0) begin
            res_item.status     = ST_ERROR;
            res_item.error_code = ERR_NAME_TERM;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          if (last_byte) begin
            if (!q_item.is_zero) begin
              res_item.status     = ST_ERROR;
              res_item.error_code = ERR_NAME_TERM;
            end else begin
              phase_nxt = PH_BCHAR;
            end
          end else begin
            bc_nxt = bc_p1[15:0];
          end
        end
        PH_BCHAR: begin
          if (!q_item.is_b) begin
            res_item.status     = ST_ERROR;
            res_item.error_code = ERR_B_CHAR;
          end else begin
            phase_nxt = PH_PLEN_HI;
          end
        end
        PH_PLEN_LO: begin
          fl_nxt = fl_lo;
          bc_nxt = 16'd0;
          if (fl_lo == 16'd0) begin
            res_item.status     = ST_ERROR;
            res_item.error_code = ERR_PART_TERM;
          end else begin
            phase_nxt = PH_PART;
          end
        end
        PH_PART: begin
          if (last_byte) begin
            if (!q_item.is_zero) begin
              res_item.status     = ST_ERROR;
              res_item.error_code = ERR_PART_TERM;
            end else begin
              res_item.status = ST_ACCEPTED;
            end
          end else begin
            res_item.part_byte  = b;
            res_item.part_valid = 1'b1;
            res_item.part_last  = (bc_p2 == {1'b0, fl});
            bc_nxt              = bc_p1[15:0];
          end
        end
        default: res_item.status = ST_IGNORED;
      endcase
      if (res_item.status != ST_PARSING) fin_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MLEN_HI;
      bc_r    <= 16'd0;
      fl_r    <= 16'd0;
      fin_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      fl_r    <= fl_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ===== rtl/fpga_bitfile_header_parser.sv =====
// Top level of the bit file header parser.
// Depends on fbhp_pkg, fbhp_fifo, fbhp_front and fbhp_back.
//
// Usage:
//  Input side is a queue: drive in_data_byte/in_restart and raise push;
//  a transaction is taken at a rising edge with push high and full low.
//  Set in_restart on the first byte of each new file.
//  Result side is a queue: while empty is low the oldest result sits on
//  the out_ ports; it is taken at a rising edge with pop high.
//  Every input byte yields exactly one result, in order.
//  A taken byte is written to the decoupling queue; the back end parses it
//  straight out of that queue and writes its result to the result queue,
//  from which the result shows on the out_ ports and can be popped.
//  Throughput: one byte per cycle while results are popped, limited by the
//  sequencer update in the back end.
//  Stalls: if pop is held low the result queue fills, the back end stops,
//  the decoupling queue fills and full rises; nothing is dropped.
//  Reset (rst_n low, synchronous) empties both queues and returns the
//  sequencer to the magic length high byte with no field counts.
module fpga_bitfile_header_parser #(
  parameter int unsigned QUEUE_DEPTH = fbhp_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH   = fbhp_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_restart,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] out_status,
  output logic [2:0] out_error_code,
  output logic [7:0] out_part_byte,
  output logic       out_part_valid,
  output logic       out_part_last
);
  import fbhp_pkg::*;

  in_item_t  fr_item, bk_item;
  out_item_t res_item, head_item;
  logic      q_wr, q_full, q_rd, q_empty;
  logic      res_wr, res_full;

  // front end: classify and enqueue
  fbhp_front u_front (
    .push         (push),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_item       (fr_item)
  );

  assign full = q_full;

  // decoupling queue between front and back
  fbhp_fifo #(.W($bits(in_item_t)), .DEPTH(QUEUE_DEPTH)) u_dq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (fr_item),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (bk_item),
    .empty   (q_empty)
  );

  // back end: header sequencer
  fbhp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (bk_item),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .res_full (res_full),
    .res_wr   (res_wr),
    .res_item (res_item)
  );

  // result queue, parts back end from the receiver
  fbhp_fifo #(.W($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_rq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_item),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (head_item),
    .empty   (empty)
  );

  assign out_status     = head_item.status;
  assign out_error_code = head_item.error_code;
  assign out_part_byte  = head_item.part_byte;
  assign out_part_valid = head_item.part_valid;
  assign out_part_last  = head_item.part_last;

endmodule

// ===== rtl/fbhp_checker.sv =====
// Port-level checker for the bit file header parser, bound to the top.
// Depends on fbhp_pkg and fpga_bitfile_header_parser.
module fbhp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic [1:0] out_status,
  input logic [2:0] out_error_code,
  input logic       out_part_valid,
  input logic       out_part_last
);
  import fbhp_pkg::*;

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_status == ST_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code inconsistent with status");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_part_last) |-> out_part_valid)
    else $error("part_last without part_valid");

  a_part_parsing: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_part_valid) |-> (out_status == ST_PARSING))
    else $error("part byte on a finishing result");

endmodule

bind fpga_bitfile_header_parser fbhp_checker u_fbhp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .full           (full),
  .empty          (empty),
  .out_status     (out_status),
  .out_error_code (out_error_code),
  .out_part_valid (out_part_valid),
  .out_part_last  (out_part_last)
);

// ===== sim/fpga_bitfile_header_parser_tb.sv =====
// Self-checking testbench for fpga_bitfile_header_parser: bit file headers, whole,
// corrupted and noisy, are pushed in one byte per transaction and every result is checked.
// Depends on fbhp_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 100ps

module fpga_bitfile_header_parser_tb;
  import fbhp_pkg::*;

  // Header predictor plus the store of expected results, oldest first.
  class header_scoreboard;
    phase_t      step;
    logic [15:0] count;
    logic [15:0] flen;
    bit          done;
    out_item_t   awaited[$];
    int          errors;
    int          results;

    function new();
      restart_parse();
      errors  = 0;
      results = 0;
    endfunction

    function void restart_parse();
      step  = PH_MLEN_HI;
      count = '0;
      flen  = '0;
      done  = 1'b0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Works out the result of one accepted byte; returns its status.
    function logic [1:0] note_byte(logic [7:0] b, logic r);
      out_item_t  want;
      logic [2:0] fault;
      logic [7:0] magic_want;
      want  = '0;
      fault = ERR_NONE;
      if (r) restart_parse();
      if (done) begin
        want.status = ST_IGNORED;
      end else begin
        case (step)
          PH_MLEN_HI: begin flen = {b, 8'h00}; step = PH_MLEN_LO; end
          PH_ALEN_HI: begin flen = {b, 8'h00}; step = PH_ALEN_LO; end
          PH_NLEN_HI: begin flen = {b, 8'h00}; step = PH_NLEN_LO; end
          PH_PLEN_HI: begin flen = {b, 8'h00}; step = PH_PLEN_LO; end
          PH_MLEN_LO: begin
            flen[7:0] = b;
            if (flen != MAGIC_SIZE) fault = ERR_MAGIC_SIZE;
            else begin
              step  = PH_MAGIC;
              count = '0;
            end
          end
          PH_MAGIC: begin
            // 0F F0 repeated four times, then 00
            magic_want = (count >= MAGIC_LAST) ? 8'h00 : (count[0] ? 8'hf0 : 8'h0f);
            if (b != magic_want) fault = ERR_MAGIC;
            else if (count >= MAGIC_LAST) step = PH_ALEN_HI;
            else count = count + 16'd1;
          end
          PH_ALEN_LO: begin
            flen[7:0] = b;
            if (flen != A_LEN) fault = ERR_A_LEN;
            else step = PH_ACHAR;
          end
          PH_ACHAR: begin
            if (b != CHAR_A) fault = ERR_A_CHAR;
            else step = PH_NLEN_HI;
          end
          PH_NLEN_LO: begin
            flen[7:0] = b;
            count     = '0;
            if (flen == 16'd0) fault = ERR_NAME_TERM;
            else step = PH_NAME;
          end
          PH_NAME: begin
            if ({16'd0, count} + 32'd1 >= {16'd0, flen}) begin
              if (b != 8'h00) fault = ERR_NAME_TERM;
              else step = PH_BCHAR;
            end else begin
              count = count + 16'd1;
            end
          end
          PH_BCHAR: begin
            if (b != CHAR_B) fault = ERR_B_CHAR;
            else step = PH_PLEN_HI;
          end
          PH_PLEN_LO: begin
            flen[7:0] = b;
            count     = '0;
            if (flen == 16'd0) fault = ERR_PART_TERM;
            else step = PH_PART;
          end
          PH_PART: begin
            if ({16'd0, count} + 32'd1 >= {16'd0, flen}) begin
              if (b != 8'h00) fault = ERR_PART_TERM;
              else want.status = ST_ACCEPTED;
            end else begin
              want.part_byte  = b;
              want.part_valid = 1'b1;
              want.part_last  = ({16'd0, count} + 32'd2 == {16'd0, flen});
              count           = count + 16'd1;
            end
          end
          default: want.status = ST_IGNORED;
        endcase
        if (fault != ERR_NONE) begin
          want.status     = ST_ERROR;
          want.error_code = fault;
        end
        if (want.status != ST_PARSING) done = 1'b1;
      end
      awaited.push_back(want);
      return want.status;
    endfunction

    task report(string what, int got_v, int want_v);
      if (errors < 40)
        $display("result %0d: %s got %0d expected %0d", results, what, got_v, want_v);
      errors++;
    endtask

    task check_result(out_item_t seen);
      out_item_t want;
      results++;
      if (awaited.size() == 0) begin
        report("result with none awaited, status", seen.status, -1);
        return;
      end
      want = awaited.pop_front();
      if (seen.status != want.status) report("status", seen.status, want.status);
      if (seen.error_code != want.error_code)
        report("error_code", seen.error_code, want.error_code);
      if (seen.part_byte != want.part_byte)
        report("part_byte", seen.part_byte, want.part_byte);
      if (seen.part_valid != want.part_valid)
        report("part_valid", seen.part_valid, want.part_valid);
      if (seen.part_last != want.part_last)
        report("part_last", seen.part_last, want.part_last);
    endtask
  endclass

  localparam int          RESET_CYCLES = 9;
  localparam int          TOTAL_ITEMS  = 850;   // input transactions, ignored bytes included
  localparam int          LONG_HOLD    = 80;    // receiver hold-off, well past the queue depth
  localparam int          DRAIN_CYCLES = 8;     // idle time after draining, for stray results
  localparam int unsigned CYCLE_LIMIT  = 500000;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       push         = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_restart   = 1'b0;
  logic       pop          = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] out_status;
  logic [2:0] out_error_code;
  logic [7:0] out_part_byte;
  logic       out_part_valid;
  logic       out_part_last;

  header_scoreboard sb;
  logic [7:0]       file_q[$];      // bytes of the file being sent
  int               live_items    = 0;
  int unsigned      cycles        = 0;
  bit               tx_gappy      = 1'b0;
  bit               rx_gappy      = 1'b0;
  bit               long_hold_req = 1'b0;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fpga_bitfile_header_parser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data_byte   (in_data_byte),
    .in_restart     (in_restart),
    .pop            (pop),
    .empty          (empty),
    .out_status     (out_status),
    .out_error_code (out_error_code),
    .out_part_byte  (out_part_byte),
    .out_part_valid (out_part_valid),
    .out_part_last  (out_part_last)
  );

  // Idle length: mostly none, otherwise a pause, now and then a long one.
  function automatic int pick_gap(bit gappy);
    int r;
    if (!gappy) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one byte and waits for the transaction. push is left high so that
  // back-to-back bytes need no second assignment within one time step; every
  // caller that stops sending lowers it through wait_drained.
  task automatic send_byte(input logic [7:0] b, input logic r);
    int gap;
    gap = pick_gap(tx_gappy);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    in_restart   <= r;
    // full is sampled as it stood before this edge
    do @(posedge clk); while (full);
    void'(sb.note_byte(b, r));
    live_items++;
  endtask

  // Sender stands still until every expected result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // A well-formed file: magic, 'a' field, design name, 'b', part name.
  // String bodies are random, with zeros inside now and then.
  task automatic build_file(input int nlen, input int plen);
    file_q.delete();
    file_q.push_back(8'h00);
    file_q.push_back(8'h09);
    for (int i = 0; i < 9; i++)
      file_q.push_back(i == 8 ? 8'h00 : (i % 2 ? 8'hf0 : 8'h0f));
    file_q.push_back(8'h00);
    file_q.push_back(8'h01);
    file_q.push_back(CHAR_A);
    file_q.push_back(8'(nlen >> 8));
    file_q.push_back(8'(nlen));
    for (int i = 1; i < nlen; i++)
      file_q.push_back($urandom_range(0, 7) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
    file_q.push_back(8'h00);
    file_q.push_back(CHAR_B);
    file_q.push_back(8'(plen >> 8));
    file_q.push_back(8'(plen));
    for (int i = 1; i < plen; i++)
      file_q.push_back($urandom_range(0, 7) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
    file_q.push_back(8'h00);
  endtask

  // Result side: every popped transaction goes to the scoreboard.
  always @(posedge clk) begin : result_monitor
    out_item_t seen;
    if (rst_n && pop && !empty) begin
      seen = {out_status, out_error_code, out_part_byte, out_part_valid, out_part_last};
      sb.check_result(seen);
    end
  end

  // Receiver: pops every cycle unless stalled. A long hold-off is requested by
  // the sender side and counted out here.
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall         = LONG_HOLD;
      end else if (stall == 0) begin
        stall = pick_gap(rx_gappy);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("fpga_bitfile_header_parser verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int file_no;
    int kind;
    int nlen;
    int plen;
    int b_at;
    int pos;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, no idling either side.
    // Length 0xFF09: wrong magic length, flagged on the low byte; then an ignored byte.
    send_byte(8'hff, 1'b1);
    send_byte(8'h09, 1'b0);
    send_byte(8'h00, 1'b0);
    // A short full header: one-byte design name, one part byte (all ones) flagged last.
    build_file(1, 2);
    file_q[file_q.size() - 2] = 8'hff;
    foreach (file_q[i]) send_byte(file_q[i], i == 0);
    wait_drained();

    // Random files: mostly well formed, some with one damaged field, some pure noise.
    file_no = 0;
    while (live_items < TOTAL_ITEMS) begin
      tx_gappy = (file_no % 5) != 4;
      rx_gappy = (file_no % 7) != 3;
      if (file_no % 9 == 8) wait_drained();
      if (file_no == 2) begin
        // receiver holds off while the sender keeps going: both queues fill, full rises
        tx_gappy      = 1'b0;
        long_hold_req = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // noise, with restart set at random points
        repeat ($urandom_range(3, 12))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end else begin
        nlen = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        plen = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        if (file_no == 5) plen = 258;    // part length with a non-zero high byte
        build_file(nlen, plen);
        if (kind >= 6) begin
          // damage one field; each error kind gets its share
          b_at = 16 + nlen;
          pos  = -1;
          case ($urandom_range(0, 7))
            0: pos = $urandom_range(0, 1);
            1: pos = $urandom_range(2, 10);
            2: pos = $urandom_range(11, 12);
            3: pos = 13;
            4: begin
              if ($urandom_range(0, 1)) begin
                file_q[14] = 8'h00;     // empty design name
                file_q[15] = 8'h00;
              end else pos = b_at - 1;
            end
            5: pos = b_at;
            6: begin
              if ($urandom_range(0, 1)) begin
                file_q[b_at + 1] = 8'h00; // empty part name
                file_q[b_at + 2] = 8'h00;
              end else pos = $urandom_range(b_at + 1, b_at + 2);
            end
            default: pos = file_q.size() - 1;
          endcase
          if (pos >= 0) file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
        end
        foreach (file_q[i]) send_byte(file_q[i], i == 0);
        // trailing bytes after a good header are ignored
        if (kind < 6)
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      file_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("fpga_bitfile_header_parser verification clean");
    end else begin
      $display("fpga_bitfile_header_parser verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fbhp_pkg.sv
rtl/fbhp_fifo.sv
rtl/fbhp_front.sv
rtl/fbhp_back.sv
rtl/fpga_bitfile_header_parser.sv
rtl/fbhp_checker.sv
sim/fpga_bitfile_header_parser_tb.sv
